// ===== rtl/rvc_pkg.sv =====
package rvc_pkg;

	// Register file size; indexes at or above it read zero and drop writes.
	localparam int unsigned RegCount = 32;
	localparam int unsigned RegIdxW  = 5;

	// Major opcodes.
	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_UPPER_PC = 7'h17;
	localparam logic [6:0] OP_JAL    = 7'h6f;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_FENCE  = 7'h0f;
	localparam logic [6:0] OP_SYSTEM = 7'h73;
	localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
	localparam logic [6:0] F7_ALT    = 7'h20;

	// Pending access codes.
	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_LOAD  = 2'd1;
	localparam logic [1:0] PEND_STORE = 2'd2;

	// Load funct3 codes.
	localparam logic [2:0] LD_B  = 3'd0;
	localparam logic [2:0] LD_H  = 3'd1;
	localparam logic [2:0] LD_BU = 3'd4;
	localparam logic [2:0] LD_HU = 3'd5;

	// Trap causes.
	localparam logic [3:0] TRAP_NONE    = 4'd0;
	localparam logic [3:0] TRAP_ILLEGAL = 4'd1;
	localparam logic [3:0] TRAP_ECALL   = 4'd2;
	localparam logic [3:0] TRAP_LD_BASE = 4'd2;
	localparam logic [3:0] TRAP_ST_BASE = 4'd5;

	typedef struct packed {
		logic        kind;
		logic [31:0] instr_word;
		logic [31:0] mem_rdata;
		logic [1:0]  mem_status;
	} in_item_t;

	typedef struct packed {
		logic        mem_read;
		logic        mem_write;
		logic [31:0] mem_addr;
		logic [1:0]  mem_size;
		logic [31:0] store_value;
		logic [31:0] fetch_pc;
		logic        fetch_ready;
		logic [3:0]  trap_code;
	} out_item_t;

	// Register file write request from the execute logic.
	typedef struct packed {
		logic               en;
		logic [RegIdxW-1:0] idx;
		logic [31:0]        data;
	} rf_wr_t;

	// Architectural state other than the register file.
	typedef struct packed {
		logic [31:0]        pc;
		logic [1:0]         pend;
		logic [RegIdxW-1:0] dest;
		logic [2:0]         ltype;
	} core_st_t;

endpackage

// ===== rtl/rvc_stream_if.sv =====
interface rvc_stream_if #(type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
	modport monitor (input valid, input payload, input ready);
endinterface

// ===== rtl/rvc_exec.sv =====
module rvc_exec (
	input  rvc_pkg::in_item_t  item,
	input  rvc_pkg::core_st_t  st,
	input  logic [31:0]        rs1_val,
	input  logic [31:0]        rs2_val,
	output rvc_pkg::core_st_t  st_next,
	output rvc_pkg::rf_wr_t    wr,
	output rvc_pkg::out_item_t res
);

	logic [6:0]  op;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] a, b, immi, imms, immb, immj, next, pc4, alu_b, alu_r, ld_v;
	logic [4:0]  sh;
	logic        alt, is_reg, ill, take;

	assign op   = item.instr_word[6:0];
	assign f3   = item.instr_word[14:12];
	assign f7   = item.instr_word[31:25];
	assign a    = rs1_val;
	assign b    = rs2_val;
	assign immi = {{20{item.instr_word[31]}}, item.instr_word[31:20]};
	assign imms = {{20{item.instr_word[31]}}, item.instr_word[31:25], item.instr_word[11:7]};
	assign immb = {{20{item.instr_word[31]}}, item.instr_word[7], item.instr_word[30:25],
		item.instr_word[11:8], 1'b0};
	assign immj = {{12{item.instr_word[31]}}, item.instr_word[19:12], item.instr_word[20],
		item.instr_word[30:21], 1'b0};
	assign pc4  = st.pc + 32'd4;

	// Shared ALU for the register and immediate forms.
	assign is_reg = (op == rvc_pkg::OP_REG);
	assign alu_b  = is_reg ? b : immi;
	assign sh     = alu_b[4:0];
	always_comb begin
		alt = is_reg ? (f7 == rvc_pkg::F7_ALT)
			: ((f3 == 3'd5) && (f7 == rvc_pkg::F7_ALT));
		case (f3)
			3'd0: alu_r = (is_reg && alt) ? a - alu_b : a + alu_b;
			3'd1: alu_r = a << sh;
			3'd2: alu_r = {31'd0, $signed(a) < $signed(alu_b)};
			3'd3: alu_r = {31'd0, a < alu_b};
			3'd4: alu_r = a ^ alu_b;
			3'd5: alu_r = alt ? 32'($signed(a) >>> sh) : a >> sh;
			3'd6: alu_r = a | alu_b;
			default: alu_r = a & alu_b;
		endcase
	end

	// Load data extension.
	always_comb begin
		unique case (st.ltype)
			rvc_pkg::LD_B:  ld_v = {{24{item.mem_rdata[7]}}, item.mem_rdata[7:0]};
			rvc_pkg::LD_H:  ld_v = {{16{item.mem_rdata[15]}}, item.mem_rdata[15:0]};
			rvc_pkg::LD_BU: ld_v = {24'd0, item.mem_rdata[7:0]};
			rvc_pkg::LD_HU: ld_v = {16'd0, item.mem_rdata[15:0]};
			default:        ld_v = item.mem_rdata;
		endcase
	end

	// Decode and execute one item.
	always_comb begin
		st_next = st;
		wr      = '0;
		res     = '0;
		ill     = 1'b0;
		take    = 1'b0;
		next    = pc4;
		if (item.kind) begin
			if (st.pend == rvc_pkg::PEND_LOAD) begin
				if (item.mem_status != 2'd0) begin
					res.trap_code = rvc_pkg::TRAP_LD_BASE + {2'd0, item.mem_status};
				end else begin
					wr = '{en: 1'b1, idx: st.dest, data: ld_v};
				end
				st_next.pend = rvc_pkg::PEND_NONE;
			end else if (st.pend == rvc_pkg::PEND_STORE) begin
				if (item.mem_status != 2'd0) begin
					res.trap_code = rvc_pkg::TRAP_ST_BASE + {2'd0, item.mem_status};
				end
				st_next.pend = rvc_pkg::PEND_NONE;
			end
		end else if (st.pend == rvc_pkg::PEND_NONE) begin
			unique case (op)
				rvc_pkg::OP_REG: begin
					ill = ((f7 != 7'd0) && (f7 != rvc_pkg::F7_ALT))
						|| ((f7 == rvc_pkg::F7_ALT) && (f3 != 3'd0) && (f3 != 3'd5));
					wr = '{en: !ill, idx: item.instr_word[11:7], data: alu_r};
				end
				rvc_pkg::OP_IMM: begin
					ill = ((f3 == 3'd1) && (f7 != 7'd0))
						|| ((f3 == 3'd5) && (f7 != 7'd0) && (f7 != rvc_pkg::F7_ALT));
					wr = '{en: !ill, idx: item.instr_word[11:7], data: alu_r};
				end
				rvc_pkg::OP_LOAD: begin
					ill = (f3 == 3'd3) || (f3 == 3'd6) || (f3 == 3'd7);
					if (!ill) begin
						res.mem_read = 1'b1;
						res.mem_addr = a + immi;
						res.mem_size = f3[1:0];
						st_next.pend  = rvc_pkg::PEND_LOAD;
						st_next.dest  = item.instr_word[11:7];
						st_next.ltype = f3;
					end
				end
				rvc_pkg::OP_STORE: begin
					ill = (f3 > 3'd2);
					if (!ill) begin
						res.mem_write = 1'b1;
						res.mem_addr  = a + imms;
						res.mem_size  = f3[1:0];
						res.store_value = (f3 == 3'd0) ? {24'd0, b[7:0]}
							: (f3 == 3'd1) ? {16'd0, b[15:0]} : b;
						st_next.pend = rvc_pkg::PEND_STORE;
					end
				end
				rvc_pkg::OP_BRANCH: begin
					case (f3)
						3'd0: take = (a == b);
						3'd1: take = (a != b);
						3'd4: take = $signed(a) < $signed(b);
						3'd5: take = $signed(a) >= $signed(b);
						3'd6: take = a < b;
						3'd7: take = a >= b;
						default: ill = 1'b1;
					endcase
					if (take) next = st.pc + immb;
				end
				rvc_pkg::OP_LUI:
					wr = '{en: 1'b1, idx: item.instr_word[11:7],
						data: {item.instr_word[31:12], 12'd0}};
				rvc_pkg::OP_UPPER_PC:
					wr = '{en: 1'b1, idx: item.instr_word[11:7],
						data: st.pc + {item.instr_word[31:12], 12'd0}};
				rvc_pkg::OP_JAL: begin
					wr   = '{en: 1'b1, idx: item.instr_word[11:7], data: pc4};
					next = st.pc + immj;
				end
				rvc_pkg::OP_JALR: begin
					ill = (f3 != 3'd0);
					if (!ill) begin
						next = (a + immi) & ~32'd1;
						wr   = '{en: 1'b1, idx: item.instr_word[11:7], data: pc4};
					end
				end
				rvc_pkg::OP_FENCE: ;
				rvc_pkg::OP_SYSTEM: begin
					if (item.instr_word == rvc_pkg::ECALL_WORD) begin
						res.trap_code = rvc_pkg::TRAP_ECALL;
					end else begin
						ill = 1'b1;
					end
				end
				default: ill = 1'b1;
			endcase
			if (ill) begin
				res.trap_code = rvc_pkg::TRAP_ILLEGAL;
				wr = '0;
			end
			st_next.pc = (res.trap_code != rvc_pkg::TRAP_NONE) ? pc4 : next;
		end
		res.fetch_pc    = st_next.pc;
		res.fetch_ready = (st_next.pend == rvc_pkg::PEND_NONE);
	end

endmodule

// ===== rtl/rv32i_decode_execute_core_unit.sv =====
// Channel | Dir | Payload                                   | Handshake
// in      | in  | kind, instr_word, mem_rdata, mem_status   | valid/ready
// out     | out | mem_read .. trap_code, one per item       | valid/ready
// cfg     | in  | start_pc (loads the program counter)        | cfg_we
// One item is executed per cycle from a flop register file; its result
// is held in a one-entry output register and the next item is taken while
// that register is empty or being emptied in the same cycle.
// A full output register that is not taken stalls the input side.
// Reset clears the register file, pending access and program counter to zero.
module rv32i_decode_execute_core_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	rvc_stream_if.sink   in_ch,
	rvc_stream_if.source out_ch
);

	logic [31:0]         regs_q [rvc_pkg::RegCount];
	rvc_pkg::core_st_t   st_q, st_next;
	rvc_pkg::rf_wr_t     wr;
	rvc_pkg::out_item_t  res, res_s1;
	rvc_pkg::in_item_t   item;
	logic                vld_s1, acc;
	logic [rvc_pkg::RegIdxW-1:0] ra, rb;
	logic [31:0]         rs1_val, rs2_val;

	assign item = in_ch.payload;
	assign ra   = item.instr_word[19:15];
	assign rb   = item.instr_word[24:20];
	assign rs1_val = (ra == '0 || 32'(ra) >= rvc_pkg::RegCount) ? 32'd0 : regs_q[ra];
	assign rs2_val = (rb == '0 || 32'(rb) >= rvc_pkg::RegCount) ? 32'd0 : regs_q[rb];

	assign in_ch.ready = !vld_s1 || out_ch.ready;
	assign acc = in_ch.valid && in_ch.ready;

	rvc_exec u_exec (
		.item(item), .st(st_q), .rs1_val(rs1_val), .rs2_val(rs2_val),
		.st_next(st_next), .wr(wr), .res(res)
	);

	// Architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			for (int k = 0; k < rvc_pkg::RegCount; k++) regs_q[k] <= '0;
		end else if (cfg_we) begin
			st_q.pc <= cfg_wdata;
		end else if (acc) begin
			st_q <= st_next;
			if (wr.en && wr.idx != '0 && 32'(wr.idx) < rvc_pkg::RegCount) begin
				regs_q[wr.idx] <= wr.data;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= 1'b1;
		end else if (out_ch.ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) res_s1 <= res;
	end

	assign out_ch.valid   = vld_s1;
	assign out_ch.payload = res_s1;

endmodule
